### rtl/core/salc_pkg.sv
// Package for the set-associative LRU cache tag store: constants and request/result types.
package salc_pkg;
    localparam int WAYS      = 8;
    localparam int SETS      = 256;
    localparam int TAG_BITS  = 20;
    localparam int WAY_W     = 3;
    localparam int SET_W     = 8;
    localparam int RANK_W    = 3;
    localparam int CNT_W     = 4;
    localparam logic [CNT_W-1:0] WAYS_RESET = 4'd8;
    localparam logic [RANK_W-1:0] RANK_MAX  = 3'd7;

    typedef struct packed {
        logic [SET_W-1:0]    set_index;
        logic [TAG_BITS-1:0] tag;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic                evicted;
        logic [TAG_BITS-1:0] evicted_tag;
        logic [WAY_W-1:0]    way_used;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
    } ctl_t;

    // One set row: per-way valid, tag and rank.
    typedef struct packed {
        logic [WAYS-1:0]                valid;
        logic [WAYS-1:0][TAG_BITS-1:0]  tags;
        logic [WAYS-1:0][RANK_W-1:0]    ranks;
    } row_t;

    localparam int ROW_W = WAYS * (1 + TAG_BITS + RANK_W);
endpackage

### rtl/core/salc_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/salc_ctrl.sv
// Controller: sequences read, update and clearing pass.
module salc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           clr_done,
    output logic           busy,
    output logic           clearing,
    output salc_pkg::ctl_t ctl
);
    import salc_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPDATE} state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_done) state_next = S_IDLE;
            S_IDLE:   if (start) state_next = S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign clearing    = (state_reg == S_CLEAR);
    assign ctl.capture = (state_reg == S_IDLE) && start;
    assign ctl.update  = (state_reg == S_UPDATE);
endmodule

### rtl/core/salc_dp.sv
// Datapath: set RAM, tag compare, LRU rank update and result register.
module salc_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  salc_pkg::ctl_t            ctl,
    input  logic                      clearing,
    output logic                      clr_done,
    input  salc_pkg::req_t            req,
    input  logic                      cfg_we,
    input  logic [salc_pkg::CNT_W-1:0] cfg_data,
    output logic                      done,
    output salc_pkg::rsp_t            rsp
);
    import salc_pkg::*;

    logic [CNT_W-1:0]    ways_reg;
    logic [SET_W-1:0]    clr_reg;
    req_t                req_reg;
    row_t                rd_row, wr_row;
    logic                we;
    logic [SET_W-1:0]    waddr;
    logic [ROW_W-1:0]    rdata;
    rsp_t                rsp_next;
    logic                done_reg;
    rsp_t                rsp_reg;

    // Config register, clearing sweep counter and done strobe register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg <= WAYS_RESET;
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) ways_reg <= cfg_data;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            done_reg <= ctl.update;
        end
    end
    assign clr_done = clearing && (clr_reg == SET_W'(SETS - 1));

    // Capture request and register the result
    always_ff @(posedge clk)
    begin
        if (ctl.capture) req_reg <= req;
        if (ctl.update) rsp_reg <= rsp_next;
    end

    salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wr_row),
        .raddr(req.set_index), .rdata(rdata)
    );
    assign rd_row = row_t'(rdata);

    // Lookup and replacement over the read row
    always_comb
    begin
        logic [CNT_W-1:0]  n;
        logic              found, free;
        logic [WAY_W-1:0]  way;
        logic [RANK_W-1:0] best, old;
        logic [CNT_W:0]    oldw;
        n = ways_reg;
        if (n == '0) n = CNT_W'(1);
        if (n > CNT_W'(WAYS)) n = CNT_W'(WAYS);
        found = 1'b0; free = 1'b0; way = '0; best = '0;
        rsp_next = '0;
        wr_row = rd_row;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (CNT_W'(i) < n && rd_row.valid[i] && rd_row.tags[i] == req_reg.tag)
            begin
                found = 1'b1;
                way = WAY_W'(i);
            end
        end
        if (!found)
        begin
            for (int i = WAYS - 1; i >= 0; i--)
            begin
                if (CNT_W'(i) < n && !rd_row.valid[i])
                begin
                    free = 1'b1;
                    way = WAY_W'(i);
                end
            end
            if (!free)
            begin
                way = '0;
                best = rd_row.ranks[0];
                for (int i = 1; i < WAYS; i++)
                begin
                    if (CNT_W'(i) < n && rd_row.ranks[i] > best)
                    begin
                        best = rd_row.ranks[i];
                        way = WAY_W'(i);
                    end
                end
                rsp_next.evicted     = 1'b1;
                rsp_next.evicted_tag = rd_row.tags[way];
            end
        end
        old  = rd_row.ranks[way];
        oldw = found ? {2'b00, old} : (CNT_W+1)'(WAYS + 1);
        for (int i = 0; i < WAYS; i++)
        begin
            if (CNT_W'(i) < n && WAY_W'(i) != way && rd_row.valid[i]
                && {2'b00, rd_row.ranks[i]} < oldw && rd_row.ranks[i] < RANK_MAX)
            begin
                wr_row.ranks[i] = rd_row.ranks[i] + 1'b1;
            end
        end
        wr_row.ranks[way] = '0;
        wr_row.valid[way] = 1'b1;
        wr_row.tags[way]  = req_reg.tag;
        rsp_next.hit      = found;
        rsp_next.way_used = way;
        if (clearing) wr_row = '0;
    end

    assign we    = clearing || ctl.update;
    assign waddr = clearing ? clr_reg : req_reg.set_index;
    assign done  = done_reg;
    assign rsp   = rsp_reg;
endmodule

### rtl/core/set_associative_lru_cache_unit.sv
// Top level of the set-associative LRU cache tag store.
// An accepted request is captured with its set row read; the update state then writes the row
// back and registers the result and its done strobe. No new request is taken during the write-back.
// The set RAM has separate read and write ports for lookup and write-back.
// After reset a clearing pass empties all 256 sets of the cache; busy is high meanwhile.
// The receiver cannot stall: each result is strobed by done for exactly one cycle.
module set_associative_lru_cache_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  salc_pkg::req_t             req,
    input  logic                       cfg_we,
    input  logic [salc_pkg::CNT_W-1:0] cfg_data,
    output logic                       done,
    output salc_pkg::rsp_t             rsp
);
    import salc_pkg::*;

    ctl_t ctl;
    logic clearing, clr_done;

    salc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .clr_done(clr_done),
        .busy(busy), .clearing(clearing), .ctl(ctl)
    );

    salc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .clearing(clearing),
        .clr_done(clr_done), .req(req), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .rsp(rsp)
    );
endmodule

### rtl/core/salc_checker.sv
// Port-level assertions for the cache tag store, bound to the top level.
module salc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input salc_pkg::rsp_t rsp
);
    import salc_pkg::*;

    // An accepted request always yields a result strobe
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done) else $error("missing result");
    // A result follows an accepted request
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2)) else $error("spurious result");
    // Busy while an accepted request's set row is written back
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy");
    // A hit never evicts
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> (!rsp.evicted && rsp.evicted_tag == '0))
        else $error("hit with eviction");
endmodule

bind set_associative_lru_cache_unit salc_checker u_salc_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

### sim/set_associative_lru_cache_unit_tb.sv
// Self-checking testbench for the set-associative LRU cache tag store.
module set_associative_lru_cache_unit_tb;
    import salc_pkg::*;

    localparam int CFG_SETTLE = 8;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_data;
    logic done;
    rsp_t rsp;

    // Predictor state: one copy of every line of the tag store
    logic              mdl_valid [SETS][WAYS] = '{default: '0};
    logic [TAG_BITS-1:0] mdl_tag [SETS][WAYS] = '{default: '0};
    logic [RANK_W-1:0] mdl_rank  [SETS][WAYS] = '{default: '0};
    logic [CNT_W-1:0]  mdl_ways;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   idle_cycles;
    bit   drive_en;
    int   burst_left;
    int   gap_left;

    set_associative_lru_cache_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Age the valid in-use ways newer than old_rank, then make way w newest
    function automatic void promote(int s, int n, int w, int old_rank);
        for (int i = 0; i < n; i++)
        begin
            if (i != w && mdl_valid[s][i] && int'(mdl_rank[s][i]) < old_rank
                && mdl_rank[s][i] < RANK_MAX)
                mdl_rank[s][i] = mdl_rank[s][i] + 1'b1;
        end
        mdl_rank[s][w] = '0;
    endfunction

    // Compute the lookup result and update the predicted tag store
    function automatic rsp_t lookup_access(req_t r);
        rsp_t o;
        int n;
        int s;
        int way;
        bit found;
        bit free_found;
        int best;
        o = '0;
        s = int'(r.set_index);
        n = (mdl_ways < 1) ? 1 : ((mdl_ways > WAYS) ? WAYS : int'(mdl_ways));
        found = 0;
        way = 0;
        for (int i = 0; i < n; i++)
            if (!found && mdl_valid[s][i] && mdl_tag[s][i] == r.tag)
            begin
                found = 1;
                way = i;
            end
        if (found)
        begin
            o.hit = 1'b1;
            promote(s, n, way, int'(mdl_rank[s][way]));
        end
        else
        begin
            free_found = 0;
            for (int i = 0; i < n; i++)
                if (!free_found && !mdl_valid[s][i])
                begin
                    free_found = 1;
                    way = i;
                end
            if (!free_found)
            begin
                best = 0;
                way = 0;
                for (int i = 0; i < n; i++)
                    if (i == 0 || int'(mdl_rank[s][i]) > best)
                    begin
                        best = int'(mdl_rank[s][i]);
                        way = i;
                    end
                o.evicted = 1'b1;
                o.evicted_tag = mdl_tag[s][way];
            end
            mdl_valid[s][way] = 1'b1;
            mdl_tag[s][way] = r.tag;
            promote(s, n, way, WAYS + 1);
        end
        o.way_used = way[WAY_W-1:0];
        return o;
    endfunction

    // Driver: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_rsps.push_back(lookup_access(req));
            if (start && busy)
                ; // hold the request until it is taken
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (drive_en && pending_reqs.size() > 0)
            begin
                start <= 1'b1;
                req <= pending_reqs.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, rsp);
                errors <= errors + 1;
            end
            else
            begin
                rsp_t e;
                e = expected_rsps.pop_front();
                if (rsp.hit !== e.hit || rsp.evicted !== e.evicted
                    || rsp.evicted_tag !== e.evicted_tag || rsp.way_used !== e.way_used)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, rsp);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Watchdog: count cycles in which no request is accepted and no result is strobed
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_ways(input logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_ways = v;
    endtask

    task automatic drain();
        drive_en = 1'b1;
        wait (pending_reqs.size() == 0 && !start && expected_rsps.size() == 0);
        drive_en = 1'b0;
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    // Queue a phase: well-formed reuse of a small tag pool, plus noise
    task automatic fill_random(int count);
        logic [TAG_BITS-1:0] pool [12];
        req_t r;
        for (int i = 0; i < 12; i++)
            pool[i] = TAG_BITS'($urandom());
        for (int i = 0; i < count; i++)
        begin
            r.set_index = ($urandom_range(0, 3) == 0) ? SET_W'($urandom())
                                                      : SET_W'($urandom_range(0, 3));
            r.tag = ($urandom_range(0, 4) == 0) ? TAG_BITS'($urandom())
                                                : pool[$urandom_range(0, 11)];
            pending_reqs.push_back(r);
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] settings [6];
        req_t r;
        settings = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
        drive_en = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        mdl_ways = WAYS_RESET;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fill one set past capacity, extremes of set and tag, hits and ties
        for (int i = 0; i < 10; i++)
        begin
            r.set_index = 8'd255;
            r.tag = (i == 0) ? '0 : ((i == 1) ? '1 : TAG_BITS'(i));
            pending_reqs.push_back(r);
        end
        for (int i = 0; i < 6; i++)
        begin
            r.set_index = 8'd0;
            r.tag = (i % 3 == 0) ? 20'hAAAAA : TAG_BITS'(20'h55555 + i);
            pending_reqs.push_back(r);
        end
        r.set_index = 8'd255;
        r.tag = '1;
        pending_reqs.push_back(r);
        drain();

        // Shrink the way count to two, then revisit set 255 with more tags than ways
        write_ways(4'd2);
        for (int i = 0; i < 5; i++)
        begin
            r.set_index = 8'd255;
            r.tag = 20'd100 + i[1:0];
            pending_reqs.push_back(r);
        end
        drain();

        // Random phases over several way counts
        for (int p = 0; p < 6; p++)
        begin
            write_ways(settings[p]);
            fill_random(280);
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
rtl/core/salc_pkg.sv
rtl/core/salc_ram.sv
rtl/core/salc_ctrl.sv
rtl/core/salc_dp.sv
rtl/core/set_associative_lru_cache_unit.sv
rtl/core/salc_checker.sv
sim/set_associative_lru_cache_unit_tb.sv
